// ===== rtl/core/idle_power_mode_governor_core_macros.svh =====
// -----------------------------------------------------------------------------
// Idle power mode governor assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// -----------------------------------------------------------------------------
`ifndef IDLE_POWER_MODE_GOVERNOR_CORE_MACROS_SVH
`define IDLE_POWER_MODE_GOVERNOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define IPMG_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ipmg assertion failed");
`define IPMG_ASSERT(lbl, prop) \
  `IPMG_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define IPMG_ASSERT_CLK(lbl, clk, rstn, prop)
`define IPMG_ASSERT(lbl, prop)
`endif

`endif

// ===== rtl/core/ipmg_pkg.sv =====
// -----------------------------------------------------------------------------
// Idle power mode governor package
// Shared types, codes, widths and reset values.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipmg_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SEC_W      = 16;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned MS_W       = 26;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);

  localparam logic              RST_AUTO_ENABLE   = 1'b0;
  localparam logic [SEC_W-1:0]  RST_DARK_S        = SEC_W'(60);
  localparam logic [SEC_W-1:0]  RST_ECO_S         = SEC_W'(300);
  localparam logic [BAND_W-1:0] RST_ECO_MHZ       = BAND_W'(80);
  localparam logic [BAND_W-1:0] RST_CRUISE_BAND   = BAND_W'(160);
  localparam logic [SEC_W-1:0]  RST_HOLDOFF_S     = SEC_W'(5);
  localparam logic [BAND_W-1:0] RST_FULL_MHZ      = BAND_W'(240);
  localparam logic              RST_SCALABLE      = 1'b1;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_CRUISE = 2'd1,
    MODE_ECO    = 2'd2,
    MODE_DOZE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_USER = 2'd1,
    ACT_DECL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_APPLIED = 2'd1,
    ST_REFUSED = 2'd2,
    ST_HELD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SWEEP_NONE     = 2'd0,
    SWEEP_REFUSERS = 2'd1,
    SWEEP_UNPROVEN = 2'd2
  } sweep_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE  = 3'd0,
    CFG_DARK_S       = 3'd1,
    CFG_ECO_S        = 3'd2,
    CFG_ECO_MHZ      = 3'd3,
    CFG_CRUISE_BAND  = 3'd4,
    CFG_HOLDOFF_S    = 3'd5,
    CFG_FULL_MHZ     = 3'd6,
    CFG_SCALABLE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic              auto_enable;
    logic [SEC_W-1:0]  dark_s;
    logic [SEC_W-1:0]  eco_s;
    logic [BAND_W-1:0] eco_mhz;
    logic [BAND_W-1:0] cruise_band;
    logic [SEC_W-1:0]  holdoff_s;
    logic [BAND_W-1:0] full_mhz;
    logic              scalable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] idle_ms;
    logic              demand_full;
    logic              full_only_held;
    logic [1:0]        want_mode;
    logic              want_display_on;
    logic [BAND_W-1:0] want_min_mhz;
    logic [BAND_W-1:0] want_max_mhz;
    logic              clock_ok;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    logic              screen;
    logic [BAND_W-1:0] band_lo;
    logic [BAND_W-1:0] band_hi;
    logic              owns;
    logic [TIME_W-1:0] last_demand;
  } state_t;

  typedef struct packed {
    mode_e             mode;
    logic              screen;
    logic [BAND_W-1:0] band_lo;
    logic [BAND_W-1:0] band_hi;
    status_e           status;
    sweep_e            sweep;
  } result_t;

  function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
    sec_to_ms = MS_W'(sec) * MS_PER_S;
  endfunction

endpackage

// ===== rtl/core/idle_power_mode_governor_core.sv =====
// -----------------------------------------------------------------------------
// Idle power mode governor core
// The item and then the result are registered; one item per cycle unless the output stalls.
// The governor state register closes the only loop: one step per item.
// Reset restores the default settings, full mode, screen on, 240 MHz band.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "idle_power_mode_governor_core_macros.svh"

module idle_power_mode_governor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [ipmg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ipmg_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [ipmg_pkg::TIME_W-1:0]       now_ms_i,
  input  logic [ipmg_pkg::TIME_W-1:0]       idle_ms_i,
  input  logic                              demand_full_i,
  input  logic                              full_only_held_i,
  input  logic [1:0]                        want_mode_i,
  input  logic                              want_display_on_i,
  input  logic [ipmg_pkg::BAND_W-1:0]       want_min_mhz_i,
  input  logic [ipmg_pkg::BAND_W-1:0]       want_max_mhz_i,
  input  logic                              clock_ok_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        mode_o,
  output logic                              display_on_o,
  output logic [ipmg_pkg::BAND_W-1:0]       band_low_mhz_o,
  output logic [ipmg_pkg::BAND_W-1:0]       band_high_mhz_o,
  output logic [1:0]                        status_o,
  output logic [1:0]                        sweep_kind_o
);

  ipmg_pkg::cfg_t    cfg_q;
  ipmg_pkg::state_t  state_q;
  ipmg_pkg::state_t  state_d;
  ipmg_pkg::item_t   item_q;
  ipmg_pkg::item_t   item_d;
  ipmg_pkg::result_t res_q;
  ipmg_pkg::result_t res_d;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              accept;
  logic              load;

  assign load       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || load;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_enable  <= ipmg_pkg::RST_AUTO_ENABLE;
      cfg_q.dark_s       <= ipmg_pkg::RST_DARK_S;
      cfg_q.eco_s        <= ipmg_pkg::RST_ECO_S;
      cfg_q.eco_mhz      <= ipmg_pkg::RST_ECO_MHZ;
      cfg_q.cruise_band  <= ipmg_pkg::RST_CRUISE_BAND;
      cfg_q.holdoff_s    <= ipmg_pkg::RST_HOLDOFF_S;
      cfg_q.full_mhz     <= ipmg_pkg::RST_FULL_MHZ;
      cfg_q.scalable     <= ipmg_pkg::RST_SCALABLE;
    end else if (cfg_we_i) begin
      case (ipmg_pkg::cfg_idx_e'(cfg_idx_i))
        ipmg_pkg::CFG_AUTO_ENABLE:  cfg_q.auto_enable  <= cfg_data_i[0];
        ipmg_pkg::CFG_DARK_S:       cfg_q.dark_s       <= cfg_data_i;
        ipmg_pkg::CFG_ECO_S:        cfg_q.eco_s        <= cfg_data_i;
        ipmg_pkg::CFG_ECO_MHZ:      cfg_q.eco_mhz      <= cfg_data_i[ipmg_pkg::BAND_W-1:0];
        ipmg_pkg::CFG_CRUISE_BAND:  cfg_q.cruise_band  <= cfg_data_i[ipmg_pkg::BAND_W-1:0];
        ipmg_pkg::CFG_HOLDOFF_S:    cfg_q.holdoff_s    <= cfg_data_i;
        ipmg_pkg::CFG_FULL_MHZ:     cfg_q.full_mhz     <= cfg_data_i[ipmg_pkg::BAND_W-1:0];
        ipmg_pkg::CFG_SCALABLE:     cfg_q.scalable     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_d.action          = action_i;
    item_d.now_ms          = now_ms_i;
    item_d.idle_ms         = idle_ms_i;
    item_d.demand_full     = demand_full_i;
    item_d.full_only_held  = full_only_held_i;
    item_d.want_mode       = want_mode_i;
    item_d.want_display_on = want_display_on_i;
    item_d.want_min_mhz    = want_min_mhz_i;
    item_d.want_max_mhz    = want_max_mhz_i;
    item_d.clock_ok        = clock_ok_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  ipmg_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= ipmg_pkg::MODE_FULL;
      state_q.screen      <= 1'b1;
      state_q.band_lo     <= ipmg_pkg::RST_FULL_MHZ;
      state_q.band_hi     <= ipmg_pkg::RST_FULL_MHZ;
      state_q.owns        <= 1'b0;
      state_q.last_demand <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mode_o          = res_q.mode;
  assign display_on_o    = res_q.screen;
  assign band_low_mhz_o  = res_q.band_lo;
  assign band_high_mhz_o = res_q.band_hi;
  assign status_o        = res_q.status;
  assign sweep_kind_o    = res_q.sweep;

  `IPMG_ASSERT(a_owns_not_resting,
    state_q.owns |-> ((state_q.mode != ipmg_pkg::MODE_FULL) || !state_q.screen))
  `IPMG_ASSERT(a_state_holds_without_load,
    !load |=> (state_q == $past(state_q)))
  `IPMG_ASSERT(a_sweep_only_applied,
    (load && (res_d.sweep != ipmg_pkg::SWEEP_NONE)) |-> (res_d.status == ipmg_pkg::ST_APPLIED))
  `IPMG_ASSERT(a_unapplied_keeps_mode,
    (load && (res_d.status != ipmg_pkg::ST_APPLIED)) |=>
      ((state_q.mode == $past(state_q.mode)) && (state_q.band_lo == $past(state_q.band_lo)) &&
       (state_q.band_hi == $past(state_q.band_hi)) && (state_q.owns == $past(state_q.owns))))

endmodule

// ===== rtl/core/ipmg_step.sv =====
// -----------------------------------------------------------------------------
// Idle power mode governor step
// Target selection and transition for one item against the current state.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipmg_step (
  input  ipmg_pkg::cfg_t    cfg_i,
  input  ipmg_pkg::state_t  state_i,
  input  ipmg_pkg::item_t   item_i,
  output ipmg_pkg::state_t  state_o,
  output ipmg_pkg::result_t result_o
);

  logic                          resting;
  logic                          tick_go;
  logic                          take_now;
  logic [ipmg_pkg::TIME_W-1:0]   ldt;
  logic [ipmg_pkg::TIME_W-1:0]   since_demand;
  logic                          cruise;
  logic                          scr_off;
  logic                          eco;
  ipmg_pkg::mode_e               tick_mode;
  logic [ipmg_pkg::BAND_W-1:0]   tick_band;

  assign resting  = (state_i.mode == ipmg_pkg::MODE_FULL) && state_i.screen;
  assign tick_go  = resting || state_i.owns;
  assign take_now = (item_i.action == ipmg_pkg::ACT_DECL) ||
                    ((item_i.action == ipmg_pkg::ACT_TICK) && tick_go &&
                     item_i.demand_full);
  assign ldt      = take_now ? item_i.now_ms : state_i.last_demand;

  assign since_demand = item_i.now_ms - ldt;
  assign cruise  = (cfg_i.cruise_band != '0) &&
                   (since_demand >= ipmg_pkg::TIME_W'(ipmg_pkg::sec_to_ms(cfg_i.holdoff_s)));
  assign scr_off = cfg_i.auto_enable && (cfg_i.dark_s != '0) &&
                   (item_i.idle_ms >=
                    ipmg_pkg::TIME_W'(ipmg_pkg::sec_to_ms(cfg_i.dark_s)));
  assign eco     = cfg_i.auto_enable && (cfg_i.eco_s != '0) &&
                   (item_i.idle_ms >= ipmg_pkg::TIME_W'(ipmg_pkg::sec_to_ms(cfg_i.eco_s))) &&
                   !item_i.full_only_held;

  always_comb begin
    if (eco) begin
      tick_band = cfg_i.eco_mhz;
      tick_mode = scr_off ? ipmg_pkg::MODE_DOZE : ipmg_pkg::MODE_ECO;
    end else if (cruise) begin
      tick_band = cfg_i.cruise_band;
      tick_mode = ipmg_pkg::MODE_CRUISE;
    end else begin
      tick_band = cfg_i.full_mhz;
      tick_mode = ipmg_pkg::MODE_FULL;
    end
  end

  always_comb begin
    ipmg_pkg::mode_e             tm;
    logic                        tscr;
    logic [ipmg_pkg::BAND_W-1:0] tlo;
    logic [ipmg_pkg::BAND_W-1:0] thi;
    logic                        by_user;
    logic                        go;
    logic                        held;
    logic                        moves;
    logic                        same;
    ipmg_pkg::status_e           status;
    ipmg_pkg::sweep_e            sweep;

    tm      = state_i.mode;
    tscr    = state_i.screen;
    tlo     = state_i.band_lo;
    thi     = state_i.band_hi;
    by_user = 1'b0;
    go      = 1'b0;
    held    = 1'b0;
    case (item_i.action)
      ipmg_pkg::ACT_TICK: begin
        if (tick_go) begin
          go   = 1'b1;
          tm   = tick_mode;
          tscr = !scr_off;
          tlo  = tick_band;
          thi  = tick_band;
        end else begin
          held = 1'b1;
        end
      end
      ipmg_pkg::ACT_USER: begin
        go      = 1'b1;
        by_user = 1'b1;
        tm      = ipmg_pkg::mode_e'(item_i.want_mode);
        tscr    = item_i.want_display_on;
        tlo     = item_i.want_min_mhz;
        thi     = item_i.want_max_mhz;
      end
      ipmg_pkg::ACT_DECL: begin
        go  = state_i.owns && (state_i.mode == ipmg_pkg::MODE_CRUISE);
        tm  = ipmg_pkg::MODE_FULL;
        tlo = cfg_i.full_mhz;
        thi = cfg_i.full_mhz;
      end
      default: begin
      end
    endcase

    moves = (tlo != state_i.band_lo) || (thi != state_i.band_hi);
    if (moves && !cfg_i.scalable) begin
      tlo   = state_i.band_lo;
      thi   = state_i.band_hi;
      moves = 1'b0;
    end
    same = (tm == state_i.mode) && (tscr == state_i.screen) &&
           (tlo == state_i.band_lo) && (thi == state_i.band_hi);

    state_o             = state_i;
    state_o.last_demand = ldt;
    status              = held ? ipmg_pkg::ST_HELD : ipmg_pkg::ST_NONE;
    sweep               = ipmg_pkg::SWEEP_NONE;
    if (go && !same) begin
      if (moves && !item_i.clock_ok) begin
        status = ipmg_pkg::ST_REFUSED;
      end else begin
        status          = ipmg_pkg::ST_APPLIED;
        state_o.mode    = tm;
        state_o.screen  = tscr;
        state_o.band_lo = tlo;
        state_o.band_hi = thi;
        state_o.owns    = !by_user && ((tm != ipmg_pkg::MODE_FULL) || !tscr);
        if (by_user && (tm > state_i.mode)) begin
          sweep = (tm == ipmg_pkg::MODE_CRUISE) ? ipmg_pkg::SWEEP_REFUSERS
                                                : ipmg_pkg::SWEEP_UNPROVEN;
        end
      end
    end

    result_o.mode    = state_o.mode;
    result_o.screen  = state_o.screen;
    result_o.band_lo = state_o.band_lo;
    result_o.band_hi = state_o.band_hi;
    result_o.status  = status;
    result_o.sweep   = sweep;
  end

endmodule

// ===== tb/testbench.sv =====
// -----------------------------------------------------------------------------
// Idle power mode governor testbench
// Drives ticks, user commands and full-only declarations through the valid and
// ready handshake. Results are compared with an in-bench governor. A directed
// table comes first, then random phases with fresh settings. Both sides stall
// at random, and once the sink holds off long enough to back up the core.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ipmg_pkg::*;

  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  localparam logic [31:0] MS_PER_SEC      = 32'd1000;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned N_ROWS          = 36;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    item_t            it;
    logic             typed;
    result_t          res;
    cfg_idx_e         idx;
    logic [15:0]      data;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  cfg_idx_e         cfg_idx     = CFG_AUTO_ENABLE;
  logic [15:0]      cfg_data    = '0;
  logic             drive_valid = 1'b0;
  item_t            drive_item  = '0;
  logic             out_ready   = 1'b0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [1:0]       mode_o;
  logic             display_on_o;
  logic [BAND_W-1:0] band_low_mhz_o;
  logic [BAND_W-1:0] band_high_mhz_o;
  logic [1:0]       status_o;
  logic [1:0]       sweep_kind_o;

  cfg_t             settings;
  state_t           gov;
  result_t          outcome_q[$];
  stim_row_t        dir_tab [N_ROWS];
  logic [31:0]      sim_now;
  logic [31:0]      sim_idle;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  logic             src_gaps;
  logic             sink_gaps;
  logic             pressure_req;

  idle_power_mode_governor_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (drive_valid),
    .in_ready_o        (in_ready_o),
    .action_i          (drive_item.action),
    .now_ms_i          (drive_item.now_ms),
    .idle_ms_i         (drive_item.idle_ms),
    .demand_full_i     (drive_item.demand_full),
    .full_only_held_i  (drive_item.full_only_held),
    .want_mode_i       (drive_item.want_mode),
    .want_display_on_i (drive_item.want_display_on),
    .want_min_mhz_i    (drive_item.want_min_mhz),
    .want_max_mhz_i    (drive_item.want_max_mhz),
    .clock_ok_i        (drive_item.clock_ok),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .mode_o            (mode_o),
    .display_on_o      (display_on_o),
    .band_low_mhz_o    (band_low_mhz_o),
    .band_high_mhz_o   (band_high_mhz_o),
    .status_o          (status_o),
    .sweep_kind_o      (sweep_kind_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic status_e commit_change(input mode_e m, input logic scr,
                                            input logic [BAND_W-1:0] lo,
                                            input logic [BAND_W-1:0] hi,
                                            input logic by_user, input logic ok,
                                            output sweep_e sw);
    state_t            prev;
    logic              moves;
    logic [BAND_W-1:0] new_lo;
    logic [BAND_W-1:0] new_hi;
    prev   = gov;
    new_lo = lo;
    new_hi = hi;
    sw     = SWEEP_NONE;
    moves  = (lo != prev.band_lo) || (hi != prev.band_hi);
    if (moves && !settings.scalable) begin
      new_lo = prev.band_lo;
      new_hi = prev.band_hi;
      moves  = 1'b0;
    end
    if (m == prev.mode && scr == prev.screen && new_lo == prev.band_lo &&
        new_hi == prev.band_hi) begin
      return ST_NONE;
    end
    if (moves && !ok) begin
      return ST_REFUSED;
    end
    gov.mode    = m;
    gov.screen  = scr;
    gov.band_lo = new_lo;
    gov.band_hi = new_hi;
    if (by_user && m > prev.mode) begin
      sw = (m == MODE_CRUISE) ? SWEEP_REFUSERS : SWEEP_UNPROVEN;
    end
    gov.owns = !by_user && (m != MODE_FULL || !scr);
    return ST_APPLIED;
  endfunction

  function automatic result_t govern(input item_t it);
    result_t           res;
    status_e           st;
    sweep_e            sw;
    logic              cruise_go;
    logic              dark;
    logic              eco_go;
    mode_e             tgt_mode;
    logic [BAND_W-1:0] tgt_band;
    st = ST_NONE;
    sw = SWEEP_NONE;
    case (it.action)
      ACT_TICK: begin
        if (!(gov.mode == MODE_FULL && gov.screen) && !gov.owns) begin
          st = ST_HELD;
        end else begin
          if (it.demand_full) begin
            gov.last_demand = it.now_ms;
          end
          cruise_go = (settings.cruise_band != 0) &&
                      ((it.now_ms - gov.last_demand) >= settings.holdoff_s * MS_PER_SEC);
          dark      = settings.auto_enable && (settings.dark_s != 0) &&
                      (it.idle_ms >= settings.dark_s * MS_PER_SEC);
          eco_go    = settings.auto_enable && (settings.eco_s != 0) &&
                      (it.idle_ms >= settings.eco_s * MS_PER_SEC) && !it.full_only_held;
          if (eco_go) begin
            tgt_band = settings.eco_mhz;
            tgt_mode = dark ? MODE_DOZE : MODE_ECO;
          end else if (cruise_go) begin
            tgt_band = settings.cruise_band;
            tgt_mode = MODE_CRUISE;
          end else begin
            tgt_band = settings.full_mhz;
            tgt_mode = MODE_FULL;
          end
          st = commit_change(tgt_mode, !dark, tgt_band, tgt_band, 1'b0, it.clock_ok, sw);
        end
      end
      ACT_USER: begin
        st = commit_change(mode_e'(it.want_mode), it.want_display_on, it.want_min_mhz,
                           it.want_max_mhz, 1'b1, it.clock_ok, sw);
      end
      ACT_DECL: begin
        gov.last_demand = it.now_ms;
        if (gov.owns && gov.mode == MODE_CRUISE) begin
          st = commit_change(MODE_FULL, gov.screen, settings.full_mhz, settings.full_mhz,
                             1'b0, it.clock_ok, sw);
        end
      end
      default: ;
    endcase
    res.mode    = gov.mode;
    res.screen  = gov.screen;
    res.band_lo = gov.band_lo;
    res.band_hi = gov.band_hi;
    res.status  = st;
    res.sweep   = sw;
    return res;
  endfunction

  function automatic int unsigned pick_setting(input int unsigned lo, input int unsigned hi,
                                               input int unsigned typ_lo,
                                               input int unsigned typ_hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  function automatic item_t draw_item();
    item_t             it;
    int unsigned       pick;
    int unsigned       step;
    logic [BAND_W-1:0] band;
    pick = $urandom_range(0, 99);
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60000) : $urandom_range(0, 2500);
    if ($urandom_range(0, 49) == 0) begin
      sim_now = $urandom;
    end else begin
      sim_now = sim_now + step;
    end
    sim_idle = sim_idle + step;
    if (pick < 55) begin
      it.action = ACT_TICK;
    end else if (pick < 78) begin
      it.action = ACT_USER;
    end else if (pick < 95) begin
      it.action = ACT_DECL;
    end else begin
      it.action = ACT_UNUSED;
    end
    it.now_ms          = sim_now;
    it.idle_ms         = ($urandom_range(0, 9) == 0) ? $urandom : sim_idle;
    it.demand_full     = ($urandom_range(0, 3) == 0);
    it.full_only_held  = ($urandom_range(0, 3) == 0);
    it.want_mode       = 2'($urandom_range(0, 3));
    it.want_display_on = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       band = settings.full_mhz;
      1:       band = settings.eco_mhz;
      2:       band = settings.cruise_band;
      default: band = 10'($urandom);
    endcase
    it.want_min_mhz = band;
    it.want_max_mhz = ($urandom_range(0, 2) == 0) ? 10'($urandom) : band;
    it.clock_ok     = ($urandom_range(0, 7) != 0);
    if (it.action == ACT_USER) begin
      sim_idle = '0;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
    int unsigned gap;
    result_t     predicted;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      drive_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    drive_valid <= 1'b1;
    drive_item  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = govern(it);
    outcome_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    drive_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_AUTO_ENABLE:  settings.auto_enable  = val[0];
      CFG_DARK_S:       settings.dark_s       = val[SEC_W-1:0];
      CFG_ECO_S:        settings.eco_s        = val[SEC_W-1:0];
      CFG_ECO_MHZ:      settings.eco_mhz      = val[BAND_W-1:0];
      CFG_CRUISE_BAND:  settings.cruise_band  = val[BAND_W-1:0];
      CFG_HOLDOFF_S:    settings.holdoff_s    = val[SEC_W-1:0];
      CFG_FULL_MHZ:     settings.full_mhz     = val[BAND_W-1:0];
      CFG_SCALABLE:     settings.scalable     = val[0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_n && out_valid_o && out_ready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, mode %0d status %0d",
                 $time, mode_o, status_o);
      end else begin
        exp_r = outcome_q.pop_front();
        check_field("mode", exp_r.mode, mode_o);
        check_field("display", exp_r.screen, display_on_o);
        check_field("band_low_mhz", exp_r.band_lo, band_low_mhz_o);
        check_field("band_high_mhz", exp_r.band_hi, band_high_mhz_o);
        check_field("status", exp_r.status, status_o);
        check_field("sweep_kind", exp_r.sweep, sweep_kind_o);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((drive_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : sink
    int unsigned stall;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (pressure_req) begin
        out_ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
        pressure_req = 1'b0;
      end
      stall = sink_gaps ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : source
    int unsigned sent;
    item_t       it;
    mismatches   = 0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    pressure_req = 1'b0;
    sim_now      = '0;
    sim_idle     = '0;
    settings     = '{RST_AUTO_ENABLE, RST_DARK_S, RST_ECO_S, RST_ECO_MHZ,
                     RST_CRUISE_BAND, RST_HOLDOFF_S, RST_FULL_MHZ, RST_SCALABLE};
    gov          = '{MODE_FULL, 1'b1, RST_FULL_MHZ, RST_FULL_MHZ, 1'b0, 32'd0};

    dir_tab = '{
      '{ROW_ITEM, '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, MODE_DOZE, 1'b1,
                   10'h3FF, 10'h3FF, 1'b1}, 1'b1,
        '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_NONE, SWEEP_NONE}, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd0, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0, 1'b1},
        1'b1, '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_NONE, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd5000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b1,
        '{MODE_CRUISE, 1'b1, 10'd160, 10'd160, ST_APPLIED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_DECL, 32'd6000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b1,
        '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_APPLIED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd20000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b0}, 1'b1,
        '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_REFUSED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd21000, 32'd0, 1'b0, 1'b0, MODE_DOZE, 1'b0, 10'd0, 10'h3FF,
                   1'b1}, 1'b1,
        '{MODE_DOZE, 1'b0, 10'd0, 10'd1023, ST_APPLIED, SWEEP_UNPROVEN},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd30000, 32'd0, 1'b1, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b1,
        '{MODE_DOZE, 1'b0, 10'd0, 10'd1023, ST_HELD, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd31000, 32'd0, 1'b0, 1'b0, MODE_CRUISE, 1'b1, 10'h3FF, 10'd0,
                   1'b1}, 1'b1,
        '{MODE_CRUISE, 1'b1, 10'd1023, 10'd0, ST_APPLIED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd32000, 32'd0, 1'b0, 1'b0, MODE_ECO, 1'b1, 10'h3FF, 10'd0,
                   1'b0}, 1'b1,
        '{MODE_ECO, 1'b1, 10'd1023, 10'd0, ST_APPLIED, SWEEP_UNPROVEN},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd33000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b1, 10'd240, 10'd240,
                   1'b0}, 1'b1,
        '{MODE_ECO, 1'b1, 10'd1023, 10'd0, ST_REFUSED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd34000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b1, 10'd240, 10'd240,
                   1'b1}, 1'b1,
        '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_APPLIED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd35000, 32'd0, 1'b0, 1'b0, MODE_CRUISE, 1'b1, 10'd240,
                   10'd240, 1'b1}, 1'b1,
        '{MODE_CRUISE, 1'b1, 10'd240, 10'd240, ST_APPLIED, SWEEP_REFUSERS},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd36000, 32'd0, 1'b0, 1'b0, MODE_CRUISE, 1'b1, 10'd240,
                   10'd240, 1'b1}, 1'b1,
        '{MODE_CRUISE, 1'b1, 10'd240, 10'd240, ST_NONE, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_DECL, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b1,
        '{MODE_CRUISE, 1'b1, 10'd240, 10'd240, ST_NONE, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd0, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b1, 10'd240, 10'd240,
                   1'b1}, 1'b1,
        '{MODE_FULL, 1'b1, 10'd240, 10'd240, ST_APPLIED, SWEEP_NONE},
        CFG_AUTO_ENABLE, 16'd0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_AUTO_ENABLE, 16'd1},
      '{ROW_CFG, '0, 1'b0, '0, CFG_DARK_S, 16'd1},
      '{ROW_CFG, '0, 1'b0, '0, CFG_ECO_S, 16'd2},
      '{ROW_CFG, '0, 1'b0, '0, CFG_SCALABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, MODE_FULL, 1'b0, 10'd0,
                   10'd0, 1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0,
                   10'd0, 1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_DECL, 32'd2000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd3000, 32'd1999, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_SCALABLE, 16'd1},
      '{ROW_CFG, '0, 1'b0, '0, CFG_CRUISE_BAND, 16'd0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_HOLDOFF_S, 16'd65535},
      '{ROW_CFG, '0, 1'b0, '0, CFG_FULL_MHZ, 16'd1},
      '{ROW_CFG, '0, 1'b0, '0, CFG_ECO_MHZ, 16'd1023},
      '{ROW_ITEM, '{ACT_TICK, 32'd4000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_DARK_S, 16'd65535},
      '{ROW_CFG, '0, 1'b0, '0, CFG_ECO_S, 16'd65535},
      '{ROW_CFG, '0, 1'b0, '0, CFG_ECO_MHZ, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd5000, 32'd65534999, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0,
                   10'd0, 1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_TICK, 32'd6000, 32'd65535000, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0,
                   10'd0, 1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_DECL, 32'd7000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b0, 10'd0, 10'd0,
                   1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0},
      '{ROW_ITEM, '{ACT_USER, 32'd8000, 32'd0, 1'b0, 1'b0, MODE_FULL, 1'b1, 10'd0, 10'd0,
                   1'b1}, 1'b0, '0, CFG_AUTO_ENABLE, 16'd0}
    };

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_reg(CFG_AUTO_ENABLE, 16'($urandom_range(0, 3) != 0));
      write_reg(CFG_DARK_S, 16'(pick_setting(0, 65535, 1, 40)));
      write_reg(CFG_ECO_S, 16'(pick_setting(0, 65535, 1, 60)));
      write_reg(CFG_ECO_MHZ, 16'(pick_setting(0, 1023, 0, 1023)));
      write_reg(CFG_CRUISE_BAND, 16'(pick_setting(0, 1023, 0, 1023)));
      write_reg(CFG_HOLDOFF_S, 16'(pick_setting(0, 65535, 1, 20)));
      write_reg(CFG_FULL_MHZ, 16'(pick_setting(1, 1023, 1, 1023)));
      write_reg(CFG_SCALABLE, 16'($urandom_range(0, 4) != 0));
      src_gaps  = phase[0];
      sink_gaps = phase[1];
      if (phase == PRESSURE_PHASE) begin
        src_gaps     = 1'b0;
        pressure_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it = draw_item();
        send_item(it, 1'b0, '0);
        if (it.action != ACT_UNUSED) begin
          sent++;
        end
      end
    end

    drive_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== idle_power_mode_governor_core.f =====
+incdir+rtl/core
rtl/core/ipmg_pkg.sv
rtl/core/ipmg_step.sv
rtl/core/idle_power_mode_governor_core.sv
tb/testbench.sv
